[rtl/fmst_pkg.sv]
package fmst_pkg;

	localparam int CMD_W = 3;
	localparam int BYTE_W = 8;
	localparam int REG_W = 9;
	localparam int SAMPLE_W = 16;
	localparam int RATE_W = 18;
	localparam int US_W = 20;
	localparam int PROD_W = SAMPLE_W + US_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam int TICK_W = 9;
	localparam int SPAN_W = 17;

	localparam logic [CMD_W-1:0] CMD_WRITE_ADDR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_HIGH_ADDR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE_DATA = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ_STATUS = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ADVANCE_TIME = 3'd4;

	localparam logic [REG_W-1:0] REG_FIRST_PRESET = 9'h002;
	localparam logic [REG_W-1:0] REG_SECOND_PRESET = 9'h003;
	localparam logic [REG_W-1:0] REG_TIMER_CONTROL = 9'h004;

	localparam int CTRL_RESET_BIT = 7;
	localparam int CTRL_MASK_FIRST_BIT = 6;
	localparam int CTRL_MASK_SECOND_BIT = 5;
	localparam int CTRL_START_FIRST_BIT = 0;
	localparam int CTRL_START_SECOND_BIT = 1;

	localparam logic [BYTE_W-1:0] HIGH_BANK_READ_DATA = 8'hFF;
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd22050;
	localparam logic [US_W-1:0] US_PER_SECOND = 20'd1000000;
	localparam logic [TICK_W-1:0] TICKS_FULL = 9'h100;
	localparam logic [SPAN_W-1:0] FIRST_PERIOD_US = 17'd80;
	localparam logic [SPAN_W-1:0] SECOND_PERIOD_US = 17'd320;

	typedef struct packed {
		logic load_item;
		logic mul_load;
		logic div_step;
		logic add_time;
		logic exec;
		logic load_out;
	} fmst_cmd_t;

	typedef struct packed {
		logic timed;
	} fmst_stat_t;

	function automatic logic [SPAN_W-1:0] tick_span(input logic [BYTE_W-1:0] preset,
			input logic [SPAN_W-1:0] period);
		logic [TICK_W-1:0] ticks;
		ticks = TICKS_FULL - {1'b0, preset};
		return SPAN_W'({{(SPAN_W-TICK_W){1'b0}}, ticks} * period);
	endfunction

endpackage

[rtl/fmst_ctrl.sv]
module fmst_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  fmst_pkg::fmst_stat_t  stat,
	output fmst_pkg::fmst_cmd_t   cmd
);
	import fmst_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_ADD = 3'd3;
	localparam logic [2:0] ST_EXEC = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = stat.timed ? ST_MUL : ST_EXEC;
				end
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_time = 1'b1;
				state_d = ST_DONE;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul_load) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/fmst_datapath.sv]
module fmst_datapath #(
	parameter int TIME_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fmst_pkg::fmst_cmd_t         cmd,
	output fmst_pkg::fmst_stat_t        stat,
	input  logic                        sample_rate_we,
	input  logic [fmst_pkg::RATE_W-1:0] sample_rate_wdata,
	input  logic [fmst_pkg::CMD_W-1:0]  command,
	input  logic [fmst_pkg::BYTE_W-1:0] port_value,
	input  logic [fmst_pkg::SAMPLE_W-1:0] sample_count,
	input  logic                        read_high_bank,
	output logic [fmst_pkg::BYTE_W-1:0] read_data,
	output logic                        forward_valid,
	output logic [fmst_pkg::REG_W-1:0]  forward_register,
	output logic [fmst_pkg::BYTE_W-1:0] forward_data
);
	import fmst_pkg::*;

	logic [RATE_W-1:0] rate_q;
	logic [CMD_W-1:0] item_cmd_q;
	logic [BYTE_W-1:0] item_value_q;
	logic [SAMPLE_W-1:0] item_samples_q;
	logic item_high_q;

	logic [PROD_W-1:0] quo_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W:0] rem_sh;
	logic [RATE_W:0] rem_diff;
	logic rem_ge;

	logic [TIME_WIDTH-1:0] time_q;
	logic [TIME_WIDTH-1:0] first_exp_q;
	logic [TIME_WIDTH-1:0] second_exp_q;
	logic [REG_W-1:0] latched_q;
	logic [BYTE_W-1:0] first_preset_q;
	logic [BYTE_W-1:0] second_preset_q;
	logic first_en_q;
	logic second_en_q;

	logic first_hit;
	logic second_hit;
	logic [BYTE_W-1:0] status;

	logic [BYTE_W-1:0] res_rd_q;
	logic res_fv_q;
	logic [REG_W-1:0] res_freg_q;
	logic [BYTE_W-1:0] res_fdata_q;

	assign stat.timed = (command == CMD_ADVANCE_TIME) && (rate_q != '0);

	assign rem_sh = {rem_q, quo_q[PROD_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, rate_q});
	assign rem_diff = rem_sh - {1'b0, rate_q};

	assign first_hit = first_en_q && (time_q > first_exp_q);
	assign second_hit = second_en_q && (time_q > second_exp_q);
	assign status = {first_hit || second_hit, first_hit, second_hit, 5'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (sample_rate_we) begin
			rate_q <= sample_rate_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_cmd_q <= command;
			item_value_q <= port_value;
			item_samples_q <= sample_count;
			item_high_q <= read_high_bank;
		end
		if (cmd.mul_load) begin
			quo_q <= {{US_W{1'b0}}, item_samples_q} * {{SAMPLE_W{1'b0}}, US_PER_SECOND};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[PROD_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			first_exp_q <= '0;
			second_exp_q <= '0;
			latched_q <= '0;
			first_preset_q <= '0;
			second_preset_q <= '0;
			first_en_q <= 1'b0;
			second_en_q <= 1'b0;
		end else begin
			if (cmd.add_time) begin
				time_q <= time_q + TIME_WIDTH'(quo_q);
			end
			if (cmd.exec) begin
				case (item_cmd_q)
					CMD_WRITE_ADDR: begin
						latched_q <= {1'b0, item_value_q};
					end
					CMD_WRITE_HIGH_ADDR: begin
						latched_q <= {1'b1, item_value_q};
					end
					CMD_WRITE_DATA: begin
						if (latched_q == REG_FIRST_PRESET) begin
							first_preset_q <= item_value_q;
							if (first_en_q) begin
								first_exp_q <= time_q + TIME_WIDTH'(
									tick_span(item_value_q, FIRST_PERIOD_US));
							end
						end else if (latched_q == REG_SECOND_PRESET) begin
							second_preset_q <= item_value_q;
							if (second_en_q) begin
								second_exp_q <= time_q + TIME_WIDTH'(
									tick_span(item_value_q, SECOND_PERIOD_US));
							end
						end else if (latched_q == REG_TIMER_CONTROL) begin
							if (item_value_q[CTRL_RESET_BIT]) begin
								first_en_q <= 1'b0;
								second_en_q <= 1'b0;
							end else begin
								if (!item_value_q[CTRL_MASK_FIRST_BIT]) begin
									first_en_q <= item_value_q[CTRL_START_FIRST_BIT];
									if (item_value_q[CTRL_START_FIRST_BIT]) begin
										first_exp_q <= time_q + TIME_WIDTH'(
											tick_span(first_preset_q, FIRST_PERIOD_US));
									end
								end
								if (!item_value_q[CTRL_MASK_SECOND_BIT]) begin
									second_en_q <= item_value_q[CTRL_START_SECOND_BIT];
									if (item_value_q[CTRL_START_SECOND_BIT]) begin
										second_exp_q <= time_q + TIME_WIDTH'(
											tick_span(second_preset_q, SECOND_PERIOD_US));
									end
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			res_rd_q <= '0;
			res_fv_q <= 1'b0;
			res_freg_q <= '0;
			res_fdata_q <= '0;
		end else if (cmd.exec) begin
			case (item_cmd_q)
				CMD_WRITE_DATA: begin
					if (latched_q != REG_FIRST_PRESET && latched_q != REG_SECOND_PRESET
							&& latched_q != REG_TIMER_CONTROL) begin
						res_fv_q <= 1'b1;
						res_freg_q <= latched_q;
						res_fdata_q <= item_value_q;
					end
				end
				CMD_READ_STATUS: begin
					res_rd_q <= item_high_q ? HIGH_BANK_READ_DATA : status;
				end
				default: begin
				end
			endcase
		end
		if (cmd.load_out) begin
			read_data <= res_rd_q;
			forward_valid <= res_fv_q;
			forward_register <= res_freg_q;
			forward_data <= res_fdata_q;
		end
	end

endmodule

[rtl/fm_synth_timer_register_port_core.sv]
// Register front end of an FM sound chip with two interval timers and a live status read.
// Each request carries one command and returns exactly one response. An advance-time
// request with a nonzero sample rate passes through the multiply state, the 36-step
// one-bit-per-cycle divider that converts samples to microseconds, and the add state.
// All other requests use the execute state. A new request is accepted once the previous
// one has been handed to the output register, so a waiting response does not block the
// next request. The sample rate may be written only while no request is in flight.
module fm_synth_timer_register_port_core #(
	parameter int TIME_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_rate_we,
	input  logic [fmst_pkg::RATE_W-1:0]   sample_rate_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fmst_pkg::CMD_W-1:0]    command,
	input  logic [fmst_pkg::BYTE_W-1:0]   port_value,
	input  logic [fmst_pkg::SAMPLE_W-1:0] sample_count,
	input  logic                          read_high_bank,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fmst_pkg::BYTE_W-1:0]   read_data,
	output logic                          forward_valid,
	output logic [fmst_pkg::REG_W-1:0]    forward_register,
	output logic [fmst_pkg::BYTE_W-1:0]   forward_data
);
	import fmst_pkg::*;

	fmst_cmd_t cmd;
	fmst_stat_t stat;

	fmst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fmst_datapath #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.sample_rate_we    (sample_rate_we),
		.sample_rate_wdata (sample_rate_wdata),
		.command           (command),
		.port_value        (port_value),
		.sample_count      (sample_count),
		.read_high_bank    (read_high_bank),
		.read_data         (read_data),
		.forward_valid     (forward_valid),
		.forward_register  (forward_register),
		.forward_data      (forward_data)
	);

endmodule

[tb/tb_fm_synth_timer_register_port_core.sv]
`timescale 1ns / 1ps

module tb_fm_synth_timer_register_port_core;
	import fmst_pkg::*;

	localparam int TIME_W = 64;
	localparam int RUN_ITEMS = 850;
	localparam int PHASES = 10;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_PHASE = 3;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd5;
	localparam logic [BYTE_W-1:0] STATUS_ANY = 8'h80;
	localparam logic [BYTE_W-1:0] STATUS_FIRST = 8'h40;
	localparam logic [BYTE_W-1:0] STATUS_SECOND = 8'h20;
	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic fwd_valid;
		logic [REG_W-1:0] fwd_reg;
		logic [BYTE_W-1:0] fwd_data;
	} port_result_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [BYTE_W-1:0] value;
		logic [SAMPLE_W-1:0] samples;
		logic high;
		bit typed;
		port_result_t result;
	} port_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_rate_we = 1'b0;
	logic [RATE_W-1:0] sample_rate_wdata = RATE_RESET;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] command = CMD_WRITE_ADDR;
	logic [BYTE_W-1:0] port_value = '0;
	logic [SAMPLE_W-1:0] sample_count = '0;
	logic read_high_bank = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [BYTE_W-1:0] read_data;
	logic forward_valid;
	logic [REG_W-1:0] forward_register;
	logic [BYTE_W-1:0] forward_data;

	logic [RATE_W-1:0] rate_setting = RATE_RESET;
	logic [TIME_W-1:0] now_us = '0;
	logic [REG_W-1:0] addr_latch = '0;
	logic [BYTE_W-1:0] preset_one = '0;
	logic [BYTE_W-1:0] preset_two = '0;
	logic run_one = 1'b0;
	logic run_two = 1'b0;
	logic [TIME_W-1:0] expiry_one = '0;
	logic [TIME_W-1:0] expiry_two = '0;

	port_result_t pending_responses[$];
	port_row_t directed_rows[$];
	int fail_count = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int sent_items = 0;
	int burst_left = 0;
	bit sender_gaps = 1'b1;
	bit hold_request = 1'b0;

	fm_synth_timer_register_port_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_rate_we(sample_rate_we),
		.sample_rate_wdata(sample_rate_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.port_value(port_value),
		.sample_count(sample_count),
		.read_high_bank(read_high_bank),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.forward_valid(forward_valid),
		.forward_register(forward_register),
		.forward_data(forward_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [TIME_W-1:0] expiry_after(input logic [BYTE_W-1:0] preset,
			input logic [SPAN_W-1:0] period);
		logic [TIME_W-1:0] ticks;
		ticks = TIME_W'(TICKS_FULL) - TIME_W'(preset);
		return now_us + ticks * TIME_W'(period);
	endfunction

	function automatic port_result_t port_response(input logic [CMD_W-1:0] cmd,
			input logic [BYTE_W-1:0] value, input logic [SAMPLE_W-1:0] samples,
			input logic high);
		port_result_t res;
		logic [TIME_W-1:0] product;
		res = '0;
		case (cmd)
			CMD_WRITE_ADDR: addr_latch = {1'b0, value};
			CMD_WRITE_HIGH_ADDR: addr_latch = {1'b1, value};
			CMD_WRITE_DATA: begin
				if (addr_latch == REG_FIRST_PRESET) begin
					preset_one = value;
					if (run_one) expiry_one = expiry_after(preset_one, FIRST_PERIOD_US);
				end else if (addr_latch == REG_SECOND_PRESET) begin
					preset_two = value;
					if (run_two) expiry_two = expiry_after(preset_two, SECOND_PERIOD_US);
				end else if (addr_latch == REG_TIMER_CONTROL) begin
					if (value[CTRL_RESET_BIT]) begin
						run_one = 1'b0;
						run_two = 1'b0;
					end else begin
						if (!value[CTRL_MASK_FIRST_BIT]) begin
							run_one = value[CTRL_START_FIRST_BIT];
							if (run_one) expiry_one = expiry_after(preset_one, FIRST_PERIOD_US);
						end
						if (!value[CTRL_MASK_SECOND_BIT]) begin
							run_two = value[CTRL_START_SECOND_BIT];
							if (run_two) expiry_two = expiry_after(preset_two, SECOND_PERIOD_US);
						end
					end
				end else begin
					res.fwd_valid = 1'b1;
					res.fwd_reg = addr_latch;
					res.fwd_data = value;
				end
			end
			CMD_READ_STATUS: begin
				if (high) begin
					res.read_data = HIGH_BANK_READ_DATA;
				end else begin
					if (run_one && now_us > expiry_one)
						res.read_data = res.read_data | STATUS_ANY | STATUS_FIRST;
					if (run_two && now_us > expiry_two)
						res.read_data = res.read_data | STATUS_ANY | STATUS_SECOND;
				end
			end
			CMD_ADVANCE_TIME: begin
				if (rate_setting != '0) begin
					product = TIME_W'(samples) * TIME_W'(US_PER_SECOND);
					now_us = now_us + product / TIME_W'(rate_setting);
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value,
			input logic [SAMPLE_W-1:0] samples, input logic high, input bit typed,
			input port_result_t typed_result);
		int gap;
		port_result_t predicted;
		@(negedge clk);
		if (sender_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (burst_left > 0) burst_left--;
		command <= cmd;
		port_value <= value;
		sample_count <= samples;
		read_high_bank <= high;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = port_response(cmd, value, samples, high);
		pending_responses.push_back(typed ? typed_result : predicted);
		sent_items++;
	endtask

	task automatic send_random(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value);
		send_request(cmd, value, SAMPLE_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
			1'b0, '0);
	endtask

	task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value,
			input logic [SAMPLE_W-1:0] samples, input logic high, input bit typed,
			input port_result_t result);
		port_row_t row;
		row.cmd = cmd;
		row.value = value;
		row.samples = samples;
		row.high = high;
		row.typed = typed;
		row.result = result;
		directed_rows.push_back(row);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] rate);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_responses.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		sample_rate_we <= 1'b1;
		sample_rate_wdata <= rate;
		@(negedge clk);
		sample_rate_we <= 1'b0;
		rate_setting = rate;
	endtask

	always @(posedge clk) begin
		port_result_t want;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (out_valid && !out_stall) begin
			if (pending_responses.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected response: rd=%h fv=%b reg=%h data=%h",
						read_data, forward_valid, forward_register, forward_data);
			end else begin
				want = pending_responses.pop_front();
				if (read_data !== want.read_data || forward_valid !== want.fwd_valid ||
						forward_register !== want.fwd_reg || forward_data !== want.fwd_data) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected rd=%h fv=%b reg=%h data=%h, got rd=%h fv=%b reg=%h data=%h",
							want.read_data, want.fwd_valid, want.fwd_reg, want.fwd_data,
							read_data, forward_valid, forward_register, forward_data);
				end
			end
		end
	end

	initial begin
		int held;
		int run_left;
		int stall_mode;
		held = 0;
		run_left = 0;
		stall_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				held++;
				if (held == HOLD_CYCLES) begin
					hold_request = 1'b0;
					held = 0;
				end
			end else begin
				if (run_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					run_left = $urandom_range(5, 60);
				end
				run_left--;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
		$display("fm_synth_timer_register_port_core verification failed");
		$finish;
	end

	initial begin
		port_result_t zero_res;
		port_result_t high_res;
		port_result_t fwd_res;
		logic [REG_W-1:0] timer_reg;
		logic [BYTE_W-1:0] value;
		logic [SAMPLE_W-1:0] samples;
		logic [RATE_W-1:0] rate;
		int pick;
		int target;
		zero_res = '0;
		high_res = '0;
		high_res.read_data = HIGH_BANK_READ_DATA;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_row(CMD_READ_STATUS, 8'h00, 16'h0000, 1'b0, 1'b1, zero_res);
		add_row(CMD_READ_STATUS, 8'h00, 16'h0000, 1'b1, 1'b1, high_res);
		add_row(CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 1'b1, zero_res);
		add_row(CMD_WRITE_ADDR, REG_FIRST_PRESET[7:0], 16'h0000, 1'b0, 1'b1, zero_res);
		add_row(CMD_WRITE_DATA, 8'h00, 16'h0000, 1'b0, 1'b1, zero_res);
		add_row(CMD_WRITE_ADDR, REG_SECOND_PRESET[7:0], 16'h0000, 1'b0, 1'b1, zero_res);
		add_row(CMD_WRITE_DATA, 8'hFF, 16'h0000, 1'b0, 1'b1, zero_res);
		add_row(CMD_WRITE_ADDR, REG_TIMER_CONTROL[7:0], 16'h0000, 1'b0, 1'b1, zero_res);
		add_row(CMD_WRITE_DATA, 8'h03, 16'h0000, 1'b0, 1'b1, zero_res);
		add_row(CMD_ADVANCE_TIME, 8'h00, 16'h0000, 1'b0, 1'b1, zero_res);
		add_row(CMD_READ_STATUS, 8'h00, 16'h0000, 1'b0, 1'b0, zero_res);
		add_row(CMD_ADVANCE_TIME, 8'h00, 16'd7, 1'b0, 1'b0, zero_res);
		add_row(CMD_READ_STATUS, 8'h00, 16'h0000, 1'b0, 1'b0, zero_res);
		add_row(CMD_ADVANCE_TIME, 8'h00, 16'd1, 1'b0, 1'b0, zero_res);
		add_row(CMD_READ_STATUS, 8'h00, 16'h0000, 1'b0, 1'b0, zero_res);
		add_row(CMD_ADVANCE_TIME, 8'h00, 16'hFFFF, 1'b0, 1'b0, zero_res);
		add_row(CMD_READ_STATUS, 8'h00, 16'h0000, 1'b0, 1'b0, zero_res);
		add_row(CMD_WRITE_DATA, 8'h80, 16'h0000, 1'b0, 1'b0, zero_res);
		add_row(CMD_READ_STATUS, 8'h00, 16'h0000, 1'b0, 1'b0, zero_res);
		add_row(CMD_WRITE_DATA, 8'h42, 16'h0000, 1'b0, 1'b0, zero_res);
		add_row(CMD_READ_STATUS, 8'h00, 16'h0000, 1'b0, 1'b0, zero_res);
		add_row(CMD_WRITE_HIGH_ADDR, 8'hFF, 16'h0000, 1'b0, 1'b1, zero_res);
		fwd_res = '{read_data: 8'h00, fwd_valid: 1'b1, fwd_reg: 9'h1FF, fwd_data: 8'hAA};
		add_row(CMD_WRITE_DATA, 8'hAA, 16'h0000, 1'b0, 1'b1, fwd_res);
		add_row(CMD_WRITE_HIGH_ADDR, REG_FIRST_PRESET[7:0], 16'h0000, 1'b0, 1'b1, zero_res);
		fwd_res = '{read_data: 8'h00, fwd_valid: 1'b1, fwd_reg: 9'h102, fwd_data: 8'h55};
		add_row(CMD_WRITE_DATA, 8'h55, 16'h0000, 1'b0, 1'b1, fwd_res);
		add_row(CMD_WRITE_ADDR, 8'hFF, 16'h0000, 1'b0, 1'b1, zero_res);
		fwd_res = '{read_data: 8'h00, fwd_valid: 1'b1, fwd_reg: 9'h0FF, fwd_data: 8'h00};
		add_row(CMD_WRITE_DATA, 8'h00, 16'h0000, 1'b0, 1'b1, fwd_res);

		foreach (directed_rows[i])
			send_request(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].samples,
				directed_rows[i].high, directed_rows[i].typed, directed_rows[i].result);

		target = sent_items;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: rate = 18'd44100;
				1: rate = 18'd1;
				2: rate = RATE_MAX;
				3: rate = '0;
				4: rate = 18'd192000;
				6: rate = 18'd48000;
				7: rate = 18'd8000;
				9: rate = RATE_RESET;
				default: rate = RATE_W'($urandom_range(1, 262143));
			endcase
			write_rate(rate);
			if (phase == HOLD_PHASE) hold_request = 1'b1;
			sender_gaps = (phase % 3 != 1);
			burst_left = 0;
			target = target + RUN_ITEMS / PHASES;
			while (sent_items < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					case ($urandom_range(0, 2))
						0: timer_reg = REG_FIRST_PRESET;
						1: timer_reg = REG_SECOND_PRESET;
						default: timer_reg = REG_TIMER_CONTROL;
					endcase
					send_random(CMD_WRITE_ADDR, timer_reg[7:0]);
					value = BYTE_W'($urandom_range(0, 255));
					if (timer_reg == REG_TIMER_CONTROL && $urandom_range(0, 7) != 0)
						value[CTRL_RESET_BIT] = 1'b0;
					send_random(CMD_WRITE_DATA, value);
				end else if (pick < 50) begin
					if ($urandom_range(0, 4) == 0)
						samples = SAMPLE_W'($urandom_range(0, 65535));
					else
						samples = SAMPLE_W'($urandom_range(0, 600));
					send_request(CMD_ADVANCE_TIME, BYTE_W'($urandom_range(0, 255)), samples,
						1'($urandom_range(0, 1)), 1'b0, '0);
				end else if (pick < 70) begin
					send_request(CMD_READ_STATUS, BYTE_W'($urandom_range(0, 255)),
						SAMPLE_W'($urandom_range(0, 65535)), ($urandom_range(0, 9) == 0),
						1'b0, '0);
				end else if (pick < 85) begin
					send_random($urandom_range(0, 1) ? CMD_WRITE_ADDR : CMD_WRITE_HIGH_ADDR,
						BYTE_W'($urandom_range(0, 255)));
					send_random(CMD_WRITE_DATA, BYTE_W'($urandom_range(0, 255)));
				end else begin
					send_random(CMD_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)));
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_responses.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_responses.size() == 0) begin
			$display("fm_synth_timer_register_port_core verification clean");
		end else begin
			$display("fm_synth_timer_register_port_core verification failed");
		end
		$finish;
	end

endmodule

[fm_synth_timer_register_port_core.f]
rtl/fmst_pkg.sv
rtl/fmst_ctrl.sv
rtl/fmst_datapath.sv
rtl/fm_synth_timer_register_port_core.sv
tb/tb_fm_synth_timer_register_port_core.sv
